/* src/rp_pkg.sv */
// Shared types and constants for the radix partition block.
package rp_pkg;

    localparam int ROW_W     = 32;
    localparam int KEY_W     = 64;
    localparam int OUT_BKT_W = 2;

    // Command kind codes
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef enum logic {
        PH_LOADING,
        PH_DRAINING
    } t_phase;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_CHK,
        ST_LOAD_BKT,
        ST_LOAD_WR,
        ST_PFX_RD,
        ST_PFX_WR,
        ST_SC_CHK,
        ST_SC_CUR,
        ST_SC_WR,
        ST_DRAIN_RD
    } t_state;

endpackage

/* src/rp_bucket.sv */
// Bucket index unit: key modulo the bucket count, iterative when not a power of two.
module rp_bucket #(
    parameter int NUM_BUCKETS = 4,
    parameter int BW          = $clog2(NUM_BUCKETS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [rp_pkg::KEY_W-1:0] i_key,
    output logic                    o_done,
    output logic [BW-1:0]           o_bucket
);

    localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

    generate
        if (IS_POW2) begin : g_mask
            logic          r_done;
            logic [BW-1:0] r_bucket;

            // Low key bits are the bucket
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_bucket <= i_key[BW-1:0];
                end
            end

            assign o_done   = r_done;
            assign o_bucket = r_bucket;
        end else begin : g_serial
            localparam int           STEPS = rp_pkg::KEY_W / 8;
            localparam int           SCW   = $clog2(STEPS);
            localparam logic [BW:0]  NB    = (BW + 1)'(NUM_BUCKETS);

            logic                     r_busy;
            logic                     r_done;
            logic [SCW-1:0]           r_step;
            logic [rp_pkg::KEY_W-1:0] r_key;
            logic [BW-1:0]            r_rem;
            logic [BW-1:0]            n_rem;

            // Eight remainder steps per cycle, key taken MSB first
            always_comb begin
                logic [BW:0] acc;
                acc   = '0;
                n_rem = r_rem;
                for (int k = 0; k < 8; k++) begin
                    acc = {n_rem, r_key[rp_pkg::KEY_W-1-k]};
                    if (acc >= NB) begin
                        acc = acc - NB;
                    end
                    n_rem = acc[BW-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_step <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_busy <= 1'b1;
                        r_step <= '0;
                    end else if (r_busy) begin
                        r_step <= r_step + SCW'(1);
                        if (r_step == SCW'(STEPS - 1)) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_key <= i_key;
                    r_rem <= '0;
                end else if (r_busy) begin
                    r_key <= r_key << 8;
                    r_rem <= n_rem;
                end
            end

            assign o_done   = r_done;
            assign o_bucket = r_rem;
        end
    endgenerate

endmodule

/* src/radix_partition.sv */
// Radix partition block: top level with sequencer, tuple stores and histogram.
//
// Command channel: a command is taken at a clock edge with i_start high and
// o_busy low. i_kind selects load (one tuple) or drain (next ordered tuple).
// A load with i_load_last closes the relation; the block then builds the
// exclusive prefix sums of the bucket counts and scatters every stored tuple
// into bucket order before it drops o_busy again.
// Result channel: o_valid pulses for one cycle with the ordered tuple; the
// receiver has no way to hold it off, so it must sample on that cycle.
// Command sequences, all set by the single-port stores and the sequencer:
//   drain            read state, result shown in the cycle after it
//   load             check, bucket wait and write states; for non-power-of-two
//                    buckets the wait is set by the bucket unit, 8 key bits per cycle
//   scatter pass     read/write per bucket, check/cursor/write per tuple
//   new relation     first clears the histogram
// After reset the histogram is cleared with o_busy high.
// Drains outside the draining phase, or past the end, give no result.
module radix_partition #(
    parameter int MAX_TUPLES  = 1024,
    parameter int NUM_BUCKETS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_kind,
    input  logic [rp_pkg::ROW_W-1:0]        i_row_id,
    input  logic [rp_pkg::KEY_W-1:0]        i_key_value,
    input  logic                            i_load_last,
    output logic                            o_valid,
    output logic [rp_pkg::ROW_W-1:0]        o_out_row_id,
    output logic [rp_pkg::KEY_W-1:0]        o_out_key,
    output logic [rp_pkg::OUT_BKT_W-1:0]    o_out_bucket,
    output logic                            o_out_last,
    output logic                            o_overflow
);

    localparam int AW = $clog2(MAX_TUPLES);
    localparam int CW = $clog2(MAX_TUPLES + 1);
    localparam int BW = $clog2(NUM_BUCKETS);
    localparam logic [BW-1:0] LAST_BKT = BW'(NUM_BUCKETS - 1);
    localparam logic [CW-1:0] CAP      = CW'(MAX_TUPLES);

    // Control registers
    rp_pkg::t_state r_state, n_state;
    rp_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]  r_total, n_total;
    logic [CW-1:0]  r_drain, n_drain;
    logic [CW-1:0]  r_sidx,  n_sidx;
    logic [CW-1:0]  r_sum,   n_sum;
    logic [BW-1:0]  r_bidx,  n_bidx;
    logic           r_ovf,   n_ovf;
    logic           r_pend,  n_pend;
    logic           r_valid, n_valid;

    // Latched command payload
    logic [rp_pkg::ROW_W-1:0] r_row;
    logic [rp_pkg::KEY_W-1:0] r_key;
    logic                     r_last;
    logic [BW-1:0]            r_bkt;

    // Output payload
    logic [rp_pkg::ROW_W-1:0]     r_o_row;
    logic [rp_pkg::KEY_W-1:0]     r_o_key;
    logic [rp_pkg::OUT_BKT_W-1:0] r_o_bkt;
    logic                         r_o_last;
    logic                         r_o_ovf;

    // Stores
    logic [rp_pkg::ROW_W-1:0] m_in_row  [MAX_TUPLES];
    logic [rp_pkg::KEY_W-1:0] m_in_key  [MAX_TUPLES];
    logic [BW-1:0]            m_in_bkt  [MAX_TUPLES];
    logic [rp_pkg::ROW_W-1:0] m_ord_row [MAX_TUPLES];
    logic [rp_pkg::KEY_W-1:0] m_ord_key [MAX_TUPLES];
    logic [BW-1:0]            m_ord_bkt [MAX_TUPLES];
    logic [CW-1:0]            m_cnt     [NUM_BUCKETS];

    logic [rp_pkg::ROW_W-1:0] r_in_rd_row;
    logic [rp_pkg::KEY_W-1:0] r_in_rd_key;
    logic [BW-1:0]            r_in_rd_bkt;
    logic [rp_pkg::ROW_W-1:0] r_ord_rd_row;
    logic [rp_pkg::KEY_W-1:0] r_ord_rd_key;
    logic [BW-1:0]            r_ord_rd_bkt;
    logic [CW-1:0]            r_cnt_rd;

    logic          in_we, ord_we, cnt_we, bkt_start, bkt_done;
    logic [BW-1:0] cnt_waddr, cnt_raddr, bkt_value;
    logic [CW-1:0] cnt_wdata;
    logic [BW+1:0] ord_bkt_ext;

    rp_bucket #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BW          (BW)
    ) u_bucket (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (bkt_start),
        .i_key    (r_key),
        .o_done   (bkt_done),
        .o_bucket (bkt_value)
    );

    // Arrival-order store
    always_ff @(posedge i_clk) begin
        if (in_we) begin
            m_in_row[r_total[AW-1:0]] <= r_row;
            m_in_key[r_total[AW-1:0]] <= r_key;
            m_in_bkt[r_total[AW-1:0]] <= bkt_value;
        end
        r_in_rd_row <= m_in_row[r_sidx[AW-1:0]];
        r_in_rd_key <= m_in_key[r_sidx[AW-1:0]];
        r_in_rd_bkt <= m_in_bkt[r_sidx[AW-1:0]];
    end

    // Partitioned store, written at the bucket cursor
    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            m_ord_row[r_cnt_rd[AW-1:0]] <= r_in_rd_row;
            m_ord_key[r_cnt_rd[AW-1:0]] <= r_in_rd_key;
            m_ord_bkt[r_cnt_rd[AW-1:0]] <= r_in_rd_bkt;
        end
        r_ord_rd_row <= m_ord_row[r_drain[AW-1:0]];
        r_ord_rd_key <= m_ord_key[r_drain[AW-1:0]];
        r_ord_rd_bkt <= m_ord_bkt[r_drain[AW-1:0]];
    end

    // Histogram, reused in place as the bucket cursors
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            m_cnt[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_rd <= m_cnt[cnt_raddr];
    end

    // Sequencer: next state and store controls
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_total   = r_total;
        n_drain   = r_drain;
        n_sidx    = r_sidx;
        n_sum     = r_sum;
        n_bidx    = r_bidx;
        n_ovf     = r_ovf;
        n_pend    = r_pend;
        n_valid   = 1'b0;
        in_we     = 1'b0;
        ord_we    = 1'b0;
        cnt_we    = 1'b0;
        cnt_waddr = r_bidx;
        cnt_wdata = '0;
        cnt_raddr = r_bidx;
        bkt_start = 1'b0;

        unique case (r_state)
            rp_pkg::ST_CLEAR: begin
                cnt_we = 1'b1;
                n_bidx = r_bidx + BW'(1);
                if (r_bidx == LAST_BKT) begin
                    n_bidx  = '0;
                    n_pend  = 1'b0;
                    n_state = r_pend ? rp_pkg::ST_LOAD_CHK : rp_pkg::ST_IDLE;
                end
            end
            rp_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_kind == rp_pkg::KIND_LOAD) begin
                        if (r_phase == rp_pkg::PH_DRAINING) begin
                            n_phase = rp_pkg::PH_LOADING;
                            n_total = '0;
                            n_drain = '0;
                            n_bidx  = '0;
                            n_pend  = 1'b1;
                            n_state = rp_pkg::ST_CLEAR;
                        end else begin
                            n_state = rp_pkg::ST_LOAD_CHK;
                        end
                    end else if (r_phase == rp_pkg::PH_DRAINING && r_drain != r_total) begin
                        n_state = rp_pkg::ST_DRAIN_RD;
                    end
                end
            end
            rp_pkg::ST_LOAD_CHK: begin
                if (r_total != CAP) begin
                    bkt_start = 1'b1;
                    n_state   = rp_pkg::ST_LOAD_BKT;
                end else begin
                    n_ovf   = 1'b1;
                    n_sum   = '0;
                    n_bidx  = '0;
                    n_state = r_last ? rp_pkg::ST_PFX_RD : rp_pkg::ST_IDLE;
                end
            end
            rp_pkg::ST_LOAD_BKT: begin
                cnt_raddr = bkt_value;
                if (bkt_done) begin
                    in_we   = 1'b1;
                    n_state = rp_pkg::ST_LOAD_WR;
                end
            end
            rp_pkg::ST_LOAD_WR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_bkt;
                cnt_wdata = r_cnt_rd + CW'(1);
                n_total   = r_total + CW'(1);
                n_sum     = '0;
                n_bidx    = '0;
                n_state   = r_last ? rp_pkg::ST_PFX_RD : rp_pkg::ST_IDLE;
            end
            rp_pkg::ST_PFX_RD: begin
                n_state = rp_pkg::ST_PFX_WR;
            end
            rp_pkg::ST_PFX_WR: begin
                cnt_we    = 1'b1;
                cnt_wdata = r_sum;
                n_sum     = r_sum + r_cnt_rd;
                if (r_bidx == LAST_BKT) begin
                    n_bidx  = '0;
                    n_sidx  = '0;
                    n_state = rp_pkg::ST_SC_CHK;
                end else begin
                    n_bidx  = r_bidx + BW'(1);
                    n_state = rp_pkg::ST_PFX_RD;
                end
            end
            rp_pkg::ST_SC_CHK: begin
                if (r_sidx == r_total) begin
                    n_phase = rp_pkg::PH_DRAINING;
                    n_drain = '0;
                    n_state = rp_pkg::ST_IDLE;
                end else begin
                    n_state = rp_pkg::ST_SC_CUR;
                end
            end
            rp_pkg::ST_SC_CUR: begin
                cnt_raddr = r_in_rd_bkt;
                n_state   = rp_pkg::ST_SC_WR;
            end
            rp_pkg::ST_SC_WR: begin
                ord_we    = 1'b1;
                cnt_we    = 1'b1;
                cnt_waddr = r_in_rd_bkt;
                cnt_wdata = r_cnt_rd + CW'(1);
                n_sidx    = r_sidx + CW'(1);
                n_state   = rp_pkg::ST_SC_CHK;
            end
            rp_pkg::ST_DRAIN_RD: begin
                n_valid = 1'b1;
                n_drain = r_drain + CW'(1);
                n_state = rp_pkg::ST_IDLE;
            end
            default: begin
                n_state = rp_pkg::ST_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rp_pkg::ST_CLEAR;
            r_phase <= rp_pkg::PH_LOADING;
            r_total <= '0;
            r_drain <= '0;
            r_sidx  <= '0;
            r_sum   <= '0;
            r_bidx  <= '0;
            r_ovf   <= 1'b0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_total <= n_total;
            r_drain <= n_drain;
            r_sidx  <= n_sidx;
            r_sum   <= n_sum;
            r_bidx  <= n_bidx;
            r_ovf   <= n_ovf;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    // Command payload capture
    always_ff @(posedge i_clk) begin
        if (i_start && r_state == rp_pkg::ST_IDLE) begin
            r_row  <= i_row_id;
            r_key  <= i_key_value;
            r_last <= i_load_last;
        end
        if (bkt_done) begin
            r_bkt <= bkt_value;
        end
    end

    // Result beat
    assign ord_bkt_ext = {2'b00, r_ord_rd_bkt};

    always_ff @(posedge i_clk) begin
        if (r_state == rp_pkg::ST_DRAIN_RD) begin
            r_o_row  <= r_ord_rd_row;
            r_o_key  <= r_ord_rd_key;
            r_o_bkt  <= ord_bkt_ext[rp_pkg::OUT_BKT_W-1:0];
            r_o_last <= ((r_drain + CW'(1)) == r_total);
            r_o_ovf  <= r_ovf;
        end
    end

    assign o_busy       = (r_state != rp_pkg::ST_IDLE);
    assign o_valid      = r_valid;
    assign o_out_row_id = r_o_row;
    assign o_out_key    = r_o_key;
    assign o_out_bucket = r_o_bkt;
    assign o_out_last   = r_o_last;
    assign o_overflow   = r_o_ovf;

endmodule

/* src/rp_checker.sv */
// Port-level assertions for the radix partition block, bound to the top level.
module rp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_busy,
    input logic i_kind,
    input logic i_valid
);

    // Reset always begins with the histogram clear
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> i_busy)
        else $error("block not busy after reset");

    // A result beat appears only while the block takes commands
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !i_busy)
        else $error("result beat while busy");

    // A drain passes through its read state, so beats never come back to back
    a_valid_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |=> !i_valid)
        else $error("back to back result beats");

    // A load never produces a beat in the next cycle
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy && i_kind == rp_pkg::KIND_LOAD) |=> !i_valid)
        else $error("result beat after a load");

endmodule

bind radix_partition rp_checker u_rp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_busy  (o_busy),
    .i_kind  (i_kind),
    .i_valid (o_valid)
);
